// ===== rtl/core/gdbpd_pkg.sv =====
package gdbpd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned VerdictW = 2;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChHash   = 8'h23;
  localparam logic [ByteW-1:0] ChNak    = 8'h2d;
  localparam logic [ByteW-1:0] ChEscape = 8'h7d;
  localparam logic [ByteW-1:0] EscXor   = 8'h20;
  localparam logic [ByteW-1:0] NibMask  = 8'h0f;

  localparam logic [PhaseW-1:0] PhHead    = 3'd0;
  localparam logic [PhaseW-1:0] PhPayload = 3'd1;
  localparam logic [PhaseW-1:0] PhChk1    = 3'd2;
  localparam logic [PhaseW-1:0] PhChk2    = 3'd3;
  localparam logic [PhaseW-1:0] PhTail    = 3'd4;
  localparam logic [PhaseW-1:0] PhNak     = 3'd5;

  typedef enum logic [KindW-1:0] {
    KIND_HEAD    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_TAIL    = 2'd2,
    KIND_VERDICT = 2'd3
  } kind_e;

  typedef enum logic [VerdictW-1:0] {
    VERD_OK         = 2'd0,
    VERD_NAK        = 2'd1,
    VERD_INCOMPLETE = 2'd2,
    VERD_MISMATCH   = 2'd3
  } verdict_e;

  // Work for the back end: an optional byte item followed by an optional verdict item.
  typedef struct packed {
    logic             byte_vld;
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             verdict_vld;
    verdict_e         verdict;
  } cmd_t;

  function automatic logic [3:0] hex_nibble(logic [ByteW-1:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = 4'(c[3:0] + 4'd9);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/gdbpd_front.sv =====
module gdbpd_front
  import gdbpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_end_i,
  input  logic             q_full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  check_q, check_d;
  logic              esc_q, esc_d;
  logic              accept;
  cmd_t              cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    check_d = check_q;
    esc_d   = esc_q;
    cmd     = '{byte_vld: 1'b0, kind: KIND_HEAD, data: '0,
                verdict_vld: 1'b0, verdict: VERD_OK};

    unique case (phase_q)
      PhHead: begin
        if (in_byte_i == ChDollar) begin
          phase_d = PhPayload;
        end else begin
          cmd.byte_vld = 1'b1;
          cmd.kind     = KIND_HEAD;
          cmd.data     = in_byte_i;
          if (in_byte_i == ChNak) begin
            phase_d = PhNak;
          end
        end
      end
      PhPayload: begin
        if (in_byte_i == ChHash) begin
          phase_d = PhChk1;
        end else begin
          sum_d = sum_q + in_byte_i;
          if (esc_q) begin
            esc_d        = 1'b0;
            cmd.byte_vld = 1'b1;
            cmd.kind     = KIND_PAYLOAD;
            cmd.data     = in_byte_i ^ EscXor;
          end else if (in_byte_i == ChEscape) begin
            esc_d = 1'b1;
          end else begin
            cmd.byte_vld = 1'b1;
            cmd.kind     = KIND_PAYLOAD;
            cmd.data     = in_byte_i;
          end
        end
      end
      PhChk1, PhChk2: begin
        check_d = {check_q[3:0] & NibMask[3:0], hex_nibble(in_byte_i)};
        phase_d = phase_q + 3'd1;
      end
      PhTail: begin
        cmd.byte_vld = 1'b1;
        cmd.kind     = KIND_TAIL;
        cmd.data     = in_byte_i;
      end
      default: begin
      end
    endcase

    if (in_end_i) begin
      cmd.verdict_vld = 1'b1;
      if (phase_d == PhTail) begin
        cmd.verdict = (sum_d == check_d) ? VERD_OK : VERD_MISMATCH;
      end else if (phase_d == PhHead || phase_d == PhPayload || phase_d == PhChk1 ||
                   phase_d == PhChk2) begin
        cmd.verdict = VERD_INCOMPLETE;
      end else begin
        cmd.verdict = VERD_NAK;
      end
      phase_d = PhHead;
      sum_d   = '0;
      check_d = '0;
      esc_d   = 1'b0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.byte_vld || cmd.verdict_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead;
      sum_q   <= '0;
      check_q <= '0;
      esc_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      check_q <= check_d;
      esc_q   <= esc_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A buffer end always leaves the parser back in the head phase with a clean sum.
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_end_i) |=> (phase_q == PhHead && sum_q == '0 && !esc_q))
    else $error("parser state not cleared after buffer end");
  // Every buffer end produces a verdict command that reaches the queue.
  a_end_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_end_i) |-> (push_o && cmd_o.verdict_vld))
    else $error("buffer end without verdict");
`endif

endmodule

// ===== rtl/core/gdbpd_queue.sv =====
module gdbpd_queue
  import gdbpd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/gdbpd_back.sv =====
module gdbpd_back
  import gdbpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cmd_t                q_cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output kind_e               out_kind_o,
  output logic                out_last_o
);

  logic             has_byte_q, has_byte_d;
  logic             has_verd_q, has_verd_d;
  kind_e            kind_q;
  logic [ByteW-1:0] data_q;
  verdict_e         verd_q;
  logic             busy;
  logic             xfer;
  logic             done;

  assign busy = has_byte_q || has_verd_q;
  assign xfer = busy && out_ready_i;
  // The held command is finished when it is empty or its final item goes out now.
  assign done  = !busy || (xfer && !(has_byte_q && has_verd_q));
  assign pop_o = q_valid_i && done;

  always_comb begin
    has_byte_d = has_byte_q;
    has_verd_d = has_verd_q;
    if (pop_o) begin
      has_byte_d = q_cmd_i.byte_vld;
      has_verd_d = q_cmd_i.verdict_vld;
    end else if (xfer) begin
      if (has_byte_q) begin
        has_byte_d = 1'b0;
      end else begin
        has_verd_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_byte_q <= 1'b0;
      has_verd_q <= 1'b0;
    end else begin
      has_byte_q <= has_byte_d;
      has_verd_q <= has_verd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= q_cmd_i.kind;
      data_q <= q_cmd_i.data;
      verd_q <= q_cmd_i.verdict;
    end
  end

  assign out_valid_o = busy;
  assign out_kind_o  = has_byte_q ? kind_q : KIND_VERDICT;
  assign out_last_o  = !has_byte_q;
  assign out_data_o  = has_byte_q ? {{(OutDataW - ByteW){1'b0}}, data_q}
                                  : {{(OutDataW - ByteW - VerdictW){1'b0}}, verd_q,
                                     {ByteW{1'b0}}};

`ifndef NO_ASSERTIONS
  // A command with a byte and a verdict sends the byte first, then the verdict.
  a_byte_then_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && has_byte_q && has_verd_q) |=> (out_valid_o && out_last_o))
    else $error("verdict lost after byte item");
`endif

endmodule

// ===== rtl/core/gdb_packet_deframer_unit.sv =====
// Packet deframer for the remote debug serial protocol. Bytes of one received buffer
// enter on the slave stream, one item per cycle, with tlast on the buffer's final byte.
// Head bytes, unescaped payload bytes and tail bytes leave on the master stream (kind
// in tuser), and every buffer ends with one verdict item carrying tlast. The input side
// takes one byte every cycle for as long as the command queue (QueueDepth entries)
// has room; the parser state is registered per accepted byte. The output side sends one
// item per cycle while the receiver is ready, so for a final byte that yields both a
// byte item and a verdict item, the byte item goes out first and the verdict item after.
module gdb_packet_deframer_unit
  import gdbpd_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [7:0] byte_out, [9:8] verdict
  output logic [KindW-1:0]    m_axis_tuser_o,   // [1:0] item_kind
  output logic                m_axis_tlast_o
);

  logic  push;
  logic  full;
  logic  pop;
  logic  q_valid;
  cmd_t  push_cmd;
  cmd_t  pop_cmd;
  kind_e out_kind;

  gdbpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i[ByteW-1:0]),
    .in_end_i   (s_axis_tlast_i),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  gdbpd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  gdbpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_kind;

`ifndef NO_ASSERTIONS
  // tlast marks verdict items and nothing else.
  a_last_is_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == KIND_VERDICT)))
    else $error("tlast does not match verdict kind");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import gdbpd_pkg::*;

  localparam int CycleLimit = 400_000;
  localparam int ReportLimit = 40;

  typedef logic [ByteW-1:0] byte_q_t[$];

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             fin;
  } byte_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] value;
    verdict_e         verdict;
    logic             fin;
  } result_t;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_CADENCE,
    RX_SPARSE
  } rx_mode_e;

  // Tracks the deframer state for every accepted byte and holds the items it must emit.
  class deframer_scoreboard;
    result_t          due_q[$];
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0] run_sum;
    logic [ByteW-1:0] rx_check;
    bit               esc_pending;
    int               errors;
    int               bytes_in;
    int               buffers;
    int               verdicts[4];

    function new();
      restart();
      errors = 0;
      bytes_in = 0;
      buffers = 0;
      foreach (verdicts[i]) verdicts[i] = 0;
    endfunction

    function void restart();
      phase = PhHead;
      run_sum = '0;
      rx_check = '0;
      esc_pending = 1'b0;
    endfunction

    function automatic logic [3:0] digit_value(logic [ByteW-1:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
    endfunction

    function void queue_item(kind_e k, logic [ByteW-1:0] v, verdict_e vd);
      result_t r;
      r = '{kind: k, value: v, verdict: vd, fin: (k == KIND_VERDICT)};
      due_q = {due_q, r};
    endfunction

    function void take_byte(logic [ByteW-1:0] ch, logic fin);
      verdict_e vd;
      bytes_in++;
      case (phase)
        PhHead: begin
          if (ch == ChDollar) begin
            phase = PhPayload;
          end else begin
            queue_item(KIND_HEAD, ch, VERD_OK);
            if (ch == ChNak) phase = PhNak;
          end
        end
        PhPayload: begin
          if (ch == ChHash) begin
            phase = PhChk1;
          end else begin
            // The raw byte goes into the sum, escape bytes included.
            run_sum = run_sum + ch;
            if (esc_pending) begin
              esc_pending = 1'b0;
              queue_item(KIND_PAYLOAD, ch ^ EscXor, VERD_OK);
            end else if (ch == ChEscape) begin
              esc_pending = 1'b1;
            end else begin
              queue_item(KIND_PAYLOAD, ch, VERD_OK);
            end
          end
        end
        PhChk1, PhChk2: begin
          rx_check = ((rx_check & NibMask) << 4) | ByteW'(digit_value(ch));
          phase = (phase == PhChk1) ? PhChk2 : PhTail;
        end
        PhTail: begin
          queue_item(KIND_TAIL, ch, VERD_OK);
        end
        default: begin
        end
      endcase
      if (fin) begin
        if (phase == PhTail) begin
          vd = (run_sum == rx_check) ? VERD_OK : VERD_MISMATCH;
        end else if (phase == PhHead || phase == PhPayload || phase == PhChk1 ||
                     phase == PhChk2) begin
          vd = VERD_INCOMPLETE;
        end else begin
          vd = VERD_NAK;
        end
        queue_item(KIND_VERDICT, '0, vd);
        verdicts[vd]++;
        buffers++;
        restart();
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= ReportLimit) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_item(input logic [OutDataW-1:0] data, input logic [KindW-1:0] kind,
                    input logic fin);
      result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected item kind %0d data %h last %b", kind, data, fin));
        return;
      end
      want = due_q.pop_front();
      if (kind !== want.kind || data[ByteW-1:0] !== want.value ||
          data[ByteW+VerdictW-1:ByteW] !== want.verdict ||
          data[OutDataW-1:ByteW+VerdictW] !== '0 || fin !== want.fin) begin
        report($sformatf({"got kind %0d byte %h verdict %0d pad %h last %b, ",
                          "want kind %0d byte %h verdict %0d last %b"},
                         kind, data[ByteW-1:0], data[ByteW+VerdictW-1:ByteW],
                         data[OutDataW-1:ByteW+VerdictW], fin,
                         want.kind, want.value, want.verdict, want.fin));
      end
    endtask

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [KindW-1:0]    m_axis_tuser_o;
  logic                m_axis_tlast_o;

  deframer_scoreboard sb;
  byte_item_t         stim_q[$];
  int                 hold_req = 0;
  int                 cycles = 0;
  int                 in_stalls = 0;

  gdb_packet_deframer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d items still due", cycles, sb.outstanding());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Inputs are noted before outputs are checked, so both sides see the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) sb.take_byte(s_tdata, s_tlast);
      if (s_tvalid && !s_axis_tready_o) in_stalls++;
      if (m_axis_tvalid_o && m_tready) begin
        sb.check_item(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end
    end
  end

  // The receiver switches between stall patterns; a hold request freezes it for a while.
  initial begin
    int       served;
    int       hold;
    int       mode_left;
    int       tick;
    rx_mode_e mode;
    served = 0;
    hold = 0;
    mode_left = 0;
    tick = 0;
    mode = RX_FREE;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req != served) begin
        served = hold_req;
        hold = 300;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RX_FREE:    m_tready <= 1'b1;
          RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
          RX_CADENCE: m_tready <= (tick % 4 != 0);
          default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [ByteW-1:0] hex_char(logic [3:0] n);
    logic [ByteW-1:0] base;
    if (n < 4'd10) return "0" + ByteW'(n);
    base = $urandom_range(0, 1) ? "A" : "a";
    return base + ByteW'(n) - 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return ChDollar;
      1:       return ChHash;
      2:       return ChNak;
      3:       return ChEscape;
      4:       return hex_char(4'($urandom));
      default: return ByteW'($urandom);
    endcase
  endfunction

  function automatic logic [ByteW-1:0] head_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom); while (b == ChDollar || b == ChNak);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] body_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom); while (b == ChHash);
    return b;
  endfunction

  task automatic push_buffer(input byte_q_t bq);
    byte_item_t it;
    foreach (bq[i]) begin
      it = '{value: bq[i], fin: (i == bq.size() - 1)};
      stim_q = {stim_q, it};
    end
  endtask

  task automatic build_frame(input int head_n, input int body_n, input int tail_n,
                             input bit corrupt, output byte_q_t bq);
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] check;
    bq = {};
    check = '0;
    repeat (head_n) bq = {bq, head_byte()};
    bq = {bq, ChDollar};
    repeat (body_n) begin
      if ($urandom_range(0, 5) == 0) begin
        bq = {bq, ChEscape};
        check = check + ChEscape;
      end
      b = body_byte();
      bq = {bq, b};
      check = check + b;
    end
    bq = {bq, ChHash};
    if (corrupt && $urandom_range(0, 1)) check = check ^ (8'h01 << $urandom_range(0, 7));
    bq = {bq, hex_char(check[7:4])};
    bq = {bq, hex_char(check[3:0])};
    // A broken digit is read as zero by the block.
    if (corrupt && bq[bq.size() - 1] == hex_char(check[3:0])) begin
      bq[bq.size() - 1 - $urandom_range(0, 1)] = "g" + ByteW'($urandom_range(0, 19));
    end
    repeat (tail_n) bq = {bq, ByteW'($urandom)};
  endtask

  task automatic add_directed();
    push_buffer({8'h00, 8'hff, ChDollar, ChEscape, 8'h5d, 8'h00, ChHash, "D", "a", 8'hff});
    push_buffer({ChNak});
    push_buffer({"x", ChNak, ChDollar});
    push_buffer({ChDollar});
    push_buffer({"q"});
    // Escape right before the hash, then two digits that are not hex.
    push_buffer({ChDollar, "a", ChEscape, ChHash, "g", "Z"});
    push_buffer({ChDollar, ChHash, "0", "0"});
    push_buffer({ChDollar, ChHash, "F"});
  endtask

  task automatic add_random_buffers(input int n_bytes);
    byte_q_t bq;
    int      goal;
    int      pick;
    int      keep;
    goal = stim_q.size() + n_bytes;
    while (stim_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_frame($urandom_range(0, 3), $urandom_range(0, 16), $urandom_range(0, 4),
                    $urandom_range(0, 4) == 0, bq);
      end else if (pick < 72) begin
        build_frame($urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(0, 3),
                    1'b0, bq);
        keep = $urandom_range(1, bq.size() - 1);
        while (bq.size() > keep) void'(bq.pop_back());
      end else if (pick < 82) begin
        bq = {};
        repeat ($urandom_range(0, 3)) bq = {bq, head_byte()};
        bq = {bq, ChNak};
        repeat ($urandom_range(0, 6)) bq = {bq, noise_byte()};
      end else begin
        bq = {};
        repeat ($urandom_range(1, 12)) bq = {bq, noise_byte()};
      end
      push_buffer(bq);
    end
  endtask

  task automatic send_all(input bit with_hold);
    byte_item_t it;
    int         burst_left;
    int         gap;
    int         sent;
    int         no_gap;
    burst_left = 0;
    sent = 0;
    no_gap = 0;
    while (stim_q.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (no_gap > 0) gap = 0;
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          s_tdata <= InDataW'($urandom);
          s_tlast <= 1'($urandom);
          repeat (gap) @(posedge clk_i);
        end
      end
      // Keep offering items back to back while the receiver holds off.
      if (with_hold && sent == 100) begin
        hold_req <= hold_req + 1;
        no_gap = 80;
      end
      it = stim_q.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= it.value;
      s_tlast <= it.fin;
      do @(posedge clk_i); while (!s_axis_tready_o);
      sent++;
      burst_left--;
      if (no_gap > 0) no_gap--;
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    repeat (2) @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    add_directed();
    send_all(1'b0);
    drain_results();
    add_random_buffers(450);
    send_all(1'b1);
    drain_results();
    add_random_buffers(450);
    send_all(1'b0);
    drain_results();
    $display("Fed %0d bytes in %0d buffers; verdicts ok %0d, nak %0d, incomplete %0d, %s%0d.",
             sb.bytes_in, sb.buffers, sb.verdicts[VERD_OK], sb.verdicts[VERD_NAK],
             sb.verdicts[VERD_INCOMPLETE], "mismatch ", sb.verdicts[VERD_MISMATCH]);
    $display("Input back-pressure held the sender for %0d cycles; %0d mismatches.",
             in_stalls, sb.errors);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
